/* hdl/tgts_pkg.sv */
// ----------------------------------------------------------------------------
// Tripod gait turn sequencer - shared package
// Widths, fixed constants, per-tick descriptor and result types.
// ----------------------------------------------------------------------------
package tgts_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int SPEED_FRAC_BITS = 8;

  localparam int A_W    = ANGLE_BITS;           // leg angle
  localparam int SPD_W  = SPEED_FRAC_BITS + 3;  // register speeds
  localparam int OSPD_W = SPEED_FRAC_BITS + 5;  // signed commanded speed
  localparam int TOL_W  = ANGLE_BITS - 2;       // tolerance
  localparam int PH_W   = 3;
  localparam int LEG_W  = 3;
  localparam int NLEG   = 6;

  localparam longint TURN      = longint'(1) << ANGLE_BITS;
  localparam longint GA_MAX    = (TURN * 37767 + 32768) >>> 16;
  localparam longint GA_RESET  = (TURN + 3) / 6;
  localparam longint TOL_RESET = (TURN * 2712 + 32768) >>> 16;
  localparam longint VMAX      = longint'(6) << SPEED_FRAC_BITS;
  localparam longint GS_RESET  = longint'(1) << SPEED_FRAC_BITS;
  localparam longint SS_RESET  = longint'(3) << SPEED_FRAC_BITS;
  localparam longint AIR_RAW   = ((TURN - GA_RESET) * GS_RESET + GA_RESET / 2) / GA_RESET;
  localparam longint AIR_RESET = (AIR_RAW > VMAX) ? VMAX : AIR_RAW;

  // air speed dividend: (TURN - ga) * gs + ga/2
  localparam int DIVN_W = A_W + SPD_W + 1;

  localparam int QDEPTH = 2;

  // gait phases
  localparam logic [PH_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PH_W-1:0] PH_STAND   = 3'd1;
  localparam logic [PH_W-1:0] PH_LIFT    = 3'd2;
  localparam logic [PH_W-1:0] PH_SWEEP_A = 3'd3;
  localparam logic [PH_W-1:0] PH_SWEEP_B = 3'd4;

  // bit i is leg i+1
  localparam logic [NLEG-1:0] TRIPOD_A = 6'b011001;  // legs 1,4,5
  localparam logic [NLEG-1:0] L1_PH3   = 6'b110011;  // legs aimed at ga/2 in phase 3

  typedef enum logic [1:0] {
    KIND_STATUS,
    KIND_STAND,
    KIND_LIFT,
    KIND_SWEEP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [PH_W-1:0]   phase;  // phase after the tick
    logic [NLEG-1:0]   dir;    // stand: leg above half a turn
  } tick_t;

  typedef struct packed {
    logic [A_W-1:0]   ga;
    logic [SPD_W-1:0] gs;
    logic [SPD_W-1:0] ss;
    logic [TOL_W-1:0] tol;
    logic [SPD_W-1:0] air;
  } cfg_t;

  typedef struct packed {
    logic [PH_W-1:0]          phase;
    logic                     cmd;
    logic [LEG_W-1:0]         leg;
    logic [A_W-1:0]           tgt;
    logic signed [OSPD_W-1:0] spd;
    logic                     last;
  } res_t;

  function automatic logic [LEG_W-1:0] lift_leg(input logic [LEG_W-1:0] k);
    logic [LEG_W-1:0] leg;
    case (k)
      3'd0:    leg = 3'd2;
      3'd1:    leg = 3'd3;
      default: leg = 3'd6;
    endcase
    return leg;
  endfunction

endpackage

/* hdl/tripod_gait_turn_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// Tripod gait turn sequencer - top level
// Alternating tripod gait, turning right, for a six-leg rotary-leg robot.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat                         | sideband
//  --------+-----+------------------------------+---------------------------
//  in_     | in  | one tick: six leg angles     | none
//  out_    | out | one status or leg command    | tuser = command, tlast
//  cfg_    | in  | APB register write / read    | pready tied high
//
//  One tick beat can be taken every cycle into a two-entry queue while the
//  queue is not full and the air speed divider is idle. The back end emits
//  one result per cycle unless the output stalls: six for a stand or sweep
//  tick, three for a lift tick, one status result otherwise, so the
//  sustained rate is set by the result serialiser. A write to the sweep angle
//  or ground speed register starts the air speed divider (a load step, then
//  one quotient bit per cycle); in_tready stays low until it is done.
//  Reset (rst_n, synchronous): phase 0, registers to their defaults, air
//  speed to the value derived from them. Output stalls back up through the
//  queue to in_tready; the output register holds its beat until taken.
//
module tripod_gait_turn_sequencer_unit import tgts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] leg1_angle, [31:16] leg2_angle, [47:32] leg3_angle,
  // [63:48] leg4_angle, [79:64] leg5_angle, [95:80] leg6_angle
  input  logic [95:0] in_tdata,

  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] gait_phase, [5:3] leg_index, [21:6] target_angle,
  // [34:22] leg_speed, [39:35] zero
  output logic [39:0] out_tdata,
  // [0] command_valid
  output logic        out_tuser,
  output logic        out_tlast,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int OUT_W = PH_W + LEG_W + A_W + OSPD_W;

  // register map, word index
  localparam logic [1:0] REG_SWEEP_ANGLE  = 2'd0;
  localparam logic [1:0] REG_GROUND_SPEED = 2'd1;
  localparam logic [1:0] REG_STAND_SPEED  = 2'd2;
  localparam logic [1:0] REG_ANGLE_TOL    = 2'd3;

  logic [A_W-1:0]   ga_r, ga_nxt;
  logic [SPD_W-1:0] gs_r, gs_nxt;
  logic [SPD_W-1:0] ss_r, ss_nxt;
  logic [TOL_W-1:0] tol_r, tol_nxt;

  logic             cfg_wr;
  logic [1:0]       cfg_idx;
  logic [A_W-1:0]   wr_ga;
  logic [SPD_W-1:0] wr_gs;
  logic             div_start, div_idle;
  logic [SPD_W-1:0] air;
  cfg_t             cfg;

  logic             in_accept;
  logic             push, pop, q_full, q_valid;
  tick_t            tick, q_head;
  res_t             out_res;

  // ---------------- configuration registers ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    // ground angle clamps to [1, max]; ground speed clamps to 6 rad/s
    wr_ga = cfg_pwdata[A_W-1:0];
    if (wr_ga == '0) begin
      wr_ga = A_W'(1);
    end else if (wr_ga > A_W'(GA_MAX)) begin
      wr_ga = A_W'(GA_MAX);
    end
    wr_gs = (cfg_pwdata[SPD_W-1:0] > SPD_W'(VMAX)) ? SPD_W'(VMAX) : cfg_pwdata[SPD_W-1:0];

    ga_nxt  = ga_r;
    gs_nxt  = gs_r;
    ss_nxt  = ss_r;
    tol_nxt = tol_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SWEEP_ANGLE:  ga_nxt  = wr_ga;
        REG_GROUND_SPEED: gs_nxt  = wr_gs;
        REG_STAND_SPEED:  ss_nxt  = cfg_pwdata[SPD_W-1:0];
        REG_ANGLE_TOL:    tol_nxt = cfg_pwdata[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ga_r  <= A_W'(GA_RESET);
      gs_r  <= SPD_W'(GS_RESET);
      ss_r  <= SPD_W'(SS_RESET);
      tol_r <= TOL_W'(TOL_RESET);
    end else begin
      ga_r  <= ga_nxt;
      gs_r  <= gs_nxt;
      ss_r  <= ss_nxt;
      tol_r <= tol_nxt;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SWEEP_ANGLE:  cfg_prdata = 32'(ga_r);
      REG_GROUND_SPEED: cfg_prdata = 32'(gs_r);
      REG_STAND_SPEED:  cfg_prdata = 32'(ss_r);
      REG_ANGLE_TOL:    cfg_prdata = 32'(tol_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // air speed follows every ground angle / ground speed write
  assign div_start = cfg_wr && (cfg_idx == REG_SWEEP_ANGLE || cfg_idx == REG_GROUND_SPEED);

  tgts_air_div u_air_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .ga    (ga_r),
    .gs    (gs_r),
    .air   (air),
    .idle  (div_idle)
  );

  assign cfg = '{ga: ga_r, gs: gs_r, ss: ss_r, tol: tol_r, air: air};

  // ---------------- front end: classify ticks ----------------
  assign in_tready = div_idle && !q_full;
  assign in_accept = in_tvalid && in_tready;

  tgts_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .angles (in_tdata[NLEG*A_W-1:0]),
    .cfg    (cfg),
    .push   (push),
    .tick   (tick)
  );

  tgts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (tick),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  // ---------------- back end: serialise results ----------------
  tgts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {(40 - OUT_W)'(0), out_res.spd, out_res.tgt, out_res.leg, out_res.phase};
  assign out_tuser = out_res.cmd;
  assign out_tlast = out_res.last;

  // ---------------- checks ----------------
  a_air_sat: assert property (@(posedge clk) disable iff (!rst_n)
    air <= SPD_W'(VMAX))
    else $error("air speed above saturation limit");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("status beat without tlast");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_res.phase <= PH_SWEEP_B)
    else $error("result carries an undefined phase");

  a_cmd_leg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_res.leg != '0 && out_res.phase != PH_IDLE)
    else $error("leg command without a leg or phase");

endmodule

/* hdl/tgts_air_div.sv */
// ----------------------------------------------------------------------------
// Tripod gait turn sequencer - air speed divider
// Restoring divider, one quotient bit per cycle, holds the derived air speed.
// ----------------------------------------------------------------------------
module tgts_air_div import tgts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [A_W-1:0]   ga,
  input  logic [SPD_W-1:0] gs,
  output logic [SPD_W-1:0] air,
  output logic             idle
);

  localparam int CNT_W = $clog2(DIVN_W);

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_LOAD = 3'b010,
    DIV_RUN  = 3'b100
  } div_st_t;

  div_st_t            st_r, st_nxt;
  logic [DIVN_W-1:0]  num_r, num_nxt;
  logic [A_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SPD_W-1:0]   air_r, air_nxt;

  logic [A_W:0]       trial;
  logic               ge;
  logic [A_W:0]       trial_sub;
  logic [DIVN_W-1:0]  quo;
  logic [DIVN_W-1:0]  prod;

  always_comb begin
    trial     = {rem_r, num_r[DIVN_W-1]};
    ge        = trial >= {1'b0, ga};
    trial_sub = trial - {1'b0, ga};
    quo       = {num_r[DIVN_W-2:0], ge};
    prod      = DIVN_W'((A_W+1)'(TURN) - {1'b0, ga}) * DIVN_W'(gs);
  end

  always_comb begin
    st_nxt  = st_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    air_nxt = air_r;
    if (start) begin
      st_nxt = DIV_LOAD;
    end else begin
      unique case (st_r)
        DIV_IDLE: begin
        end
        DIV_LOAD: begin
          num_nxt = prod + DIVN_W'(ga >> 1);
          rem_nxt = '0;
          cnt_nxt = CNT_W'(DIVN_W - 1);
          st_nxt  = DIV_RUN;
        end
        DIV_RUN: begin
          num_nxt = quo;
          rem_nxt = ge ? trial_sub[A_W-1:0] : trial[A_W-1:0];
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == '0) begin
            air_nxt = (quo > DIVN_W'(VMAX)) ? SPD_W'(VMAX) : quo[SPD_W-1:0];
            st_nxt  = DIV_IDLE;
          end
        end
        default: st_nxt = DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= DIV_IDLE;
      air_r <= SPD_W'(AIR_RESET);
    end else begin
      st_r  <= st_nxt;
      air_r <= air_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign air  = air_r;
  assign idle = (st_r == DIV_IDLE);

endmodule

/* hdl/tgts_front.sv */
// ----------------------------------------------------------------------------
// Tripod gait turn sequencer - front end
// Checks the six leg angles against the phase targets, advances the phase
// and pushes one tick descriptor per accepted beat.
// ----------------------------------------------------------------------------
module tgts_front import tgts_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [NLEG*A_W-1:0] angles,
  input  cfg_t                cfg,
  output logic                push,
  output tick_t               tick
);

  logic [PH_W-1:0] phase_r, phase_nxt;
  logic [NLEG-1:0] nz, lb, sw, l1, above;
  logic            all_nz, all_lift, all_sw;

  function automatic logic near_zero(input logic [A_W-1:0] a, input logic [TOL_W-1:0] tol);
    logic [A_W:0] ax;
    logic [A_W:0] rest;
    logic [A_W:0] t;
    ax   = {1'b0, a};
    rest = (A_W+1)'(TURN) - ax;
    t    = (A_W+1)'(tol);
    return (ax < t) || (rest < t);
  endfunction

  function automatic logic near_half(input logic [A_W-1:0] a, input logic [TOL_W-1:0] tol);
    logic signed [A_W+1:0] d;
    logic        [A_W+1:0] m;
    d = $signed({2'b00, a}) - $signed((A_W+2)'(TURN / 2));
    m = (d < 0) ? $unsigned(-d) : $unsigned(d);
    return m < (A_W+2)'(tol);
  endfunction

  function automatic logic near_sweep(input logic [A_W-1:0] a, input logic sel_l1,
                                      input logic [A_W-1:0] ga, input logic [TOL_W-1:0] tol);
    logic signed [A_W+2:0] a2;
    logic signed [A_W+2:0] t2;
    logic signed [A_W+2:0] d;
    logic        [A_W+2:0] m;
    a2 = $signed({2'b00, a, 1'b0});
    t2 = sel_l1 ? $signed({3'b000, ga})
                : $signed((A_W+3)'(2 * TURN) - {3'b000, ga});
    d  = a2 - t2;
    m  = (d < 0) ? $unsigned(-d) : $unsigned(d);
    return m < (A_W+3)'({tol, 1'b0});
  endfunction

  always_comb begin
    l1 = (phase_r == PH_SWEEP_A) ? L1_PH3 : ~L1_PH3;
    for (int i = 0; i < NLEG; i++) begin
      nz[i]    = near_zero(angles[i*A_W +: A_W], cfg.tol);
      lb[i]    = near_half(angles[i*A_W +: A_W], cfg.tol);
      sw[i]    = near_sweep(angles[i*A_W +: A_W], l1[i], cfg.ga, cfg.tol);
      above[i] = angles[i*A_W +: A_W] > A_W'(TURN / 2);
    end
    all_nz   = &nz;
    all_lift = &((TRIPOD_A & nz) | (~TRIPOD_A & lb));
    all_sw   = &sw;
  end

  // phase codes outside 1..4 behave as not started
  always_comb begin
    tick.dir   = above;
    tick.kind  = KIND_STATUS;
    tick.phase = phase_r;
    priority if (phase_r == PH_SWEEP_A || phase_r == PH_SWEEP_B) begin
      if (all_sw) begin
        tick.kind  = KIND_SWEEP;
        tick.phase = (phase_r == PH_SWEEP_A) ? PH_SWEEP_B : PH_SWEEP_A;
      end
    end else if (phase_r == PH_LIFT) begin
      if (all_lift) begin
        tick.kind  = KIND_SWEEP;
        tick.phase = PH_SWEEP_A;
      end
    end else begin
      if (all_nz) begin
        tick.kind  = KIND_LIFT;
        tick.phase = PH_LIFT;
      end else if (phase_r != PH_STAND) begin
        tick.kind  = KIND_STAND;
        tick.phase = PH_STAND;
      end
    end
    phase_nxt = accept ? tick.phase : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  assign push = accept;

endmodule

/* hdl/tgts_queue.sv */
// ----------------------------------------------------------------------------
// Tripod gait turn sequencer - tick queue
// Short FIFO of tick descriptors between front and back end.
// ----------------------------------------------------------------------------
module tgts_queue import tgts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  tick_t push_data,
  input  logic  pop,
  output logic  full,
  output logic  valid,
  output tick_t head
);

  localparam int QA_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W = $clog2(QDEPTH + 1);

  tick_t           mem_r [QDEPTH];
  logic [QA_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QA_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QA_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign full  = (cnt_r == QC_W'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rp_r];

endmodule

/* hdl/tgts_back.sv */
// ----------------------------------------------------------------------------
// Tripod gait turn sequencer - back end
// Expands each tick descriptor into its result beats, one per cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module tgts_back import tgts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  tick_t q_head,
  output logic  pop,
  input  cfg_t  cfg,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int X5_W    = SPD_W + 2;
  localparam int DIV5_SH = X5_W + 2;
  localparam int DIV5_M  = (2 ** DIV5_SH + 4) / 5;

  logic [LEG_W-1:0]          cnt_r, cnt_nxt;
  logic                      valid_r, valid_nxt;
  res_t                      res_r, res_nxt;
  res_t                      cur;
  logic                      load;
  logic [SPD_W+1:0]          lift_x;
  logic [X5_W-1:0]           stand_x;
  logic [X5_W+DIV5_SH-1:0]   stand_p;
  logic [OSPD_W-1:0]         stand_neg_mag;
  logic [A_W-1:0]            half_ga;
  logic [A_W:0]              far_tgt;
  logic                      sel_l1, ground, odd_leg;
  logic [SPD_W-1:0]          mag;

  always_comb begin
    lift_x        = {1'b0, cfg.ss, 1'b0} + (SPD_W+2)'(cfg.ss) + 1'b1;
    stand_x       = {cfg.ss, 2'b10};
    stand_p       = stand_x * (X5_W+DIV5_SH)'(DIV5_M);
    stand_neg_mag = OSPD_W'(stand_p >> DIV5_SH);
    half_ga       = cfg.ga >> 1;
    far_tgt       = (A_W+1)'(TURN) - {1'b0, half_ga};
    sel_l1        = (q_head.phase == PH_SWEEP_A) ? L1_PH3[cnt_r] : ~L1_PH3[cnt_r];
    ground        = (q_head.phase == PH_SWEEP_A) ? TRIPOD_A[cnt_r] : ~TRIPOD_A[cnt_r];
    odd_leg       = ~cnt_r[0];
    mag           = ground ? cfg.gs : cfg.air;
  end

  always_comb begin
    cur.phase = q_head.phase;
    cur.cmd   = 1'b1;
    cur.leg   = cnt_r + 1'b1;
    cur.tgt   = '0;
    cur.spd   = '0;
    cur.last  = (cnt_r == LEG_W'(NLEG - 1));
    unique case (q_head.kind)
      KIND_STATUS: begin
        cur.cmd  = 1'b0;
        cur.leg  = '0;
        cur.last = 1'b1;
      end
      KIND_STAND: begin
        cur.spd = q_head.dir[cnt_r] ? $signed(OSPD_W'(cfg.ss)) : -$signed(stand_neg_mag);
      end
      KIND_LIFT: begin
        cur.leg  = lift_leg(cnt_r);
        cur.tgt  = A_W'(TURN / 2);
        cur.spd  = $signed(OSPD_W'(lift_x >> 1));
        cur.last = (cnt_r == 3'd2);
      end
      KIND_SWEEP: begin
        cur.tgt = sel_l1 ? half_ga : far_tgt[A_W-1:0];
        cur.spd = odd_leg ? $signed(OSPD_W'(mag)) : -$signed(OSPD_W'(mag));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    load      = q_valid && (!valid_r || out_ready);
    pop       = load && cur.last;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      cnt_nxt   = cur.last ? '0 : cnt_r + 1'b1;
      valid_nxt = 1'b1;
      res_nxt   = cur;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
